[rtl/adc_piecewise_linear_calibration_core_defines.svh]
// Assertion macros used by the calibration core port checker.
`ifndef ADC_PIECEWISE_LINEAR_CALIBRATION_CORE_DEFINES_SVH
`define ADC_PIECEWISE_LINEAR_CALIBRATION_CORE_DEFINES_SVH

// Condition must hold on every clock out of reset.
`define APLC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent in this cycle implies consequent in the next one.
`define APLC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/aplc_pkg.sv]
// Package: breakpoint table, segment ROM entry type and fixed widths.
package aplc_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int OUT_W        = 14;
    localparam int IN_TDATA_W   = 16;
    localparam int OUT_TDATA_W  = 16;
    localparam int OUT_MAX      = 8191;

    localparam int NUM_POINTS   = 16;
    localparam int NUM_SEGS     = NUM_POINTS - 1;
    localparam int SEG_W        = $clog2(NUM_SEGS);

    // segment entry field widths
    localparam int BP_W         = 11;   // breakpoint code
    localparam int BASE_W       = 19;   // y1 * d, signed
    localparam int DY_W         = 9;    // y2 - y1, signed
    localparam int D_W          = 7;    // x2 - x1
    localparam int D2_W         = D_W + 1;
    localparam int LIM_W        = 21;   // saturation limit on 2N
    localparam int RW           = 15;   // reciprocal of 2d
    localparam int TW           = 21;   // 2N + d when not saturated
    localparam int Q_W          = 14;
    localparam int RECIP_SHIFT  = 21;
    localparam int RECIP_NUM    = 2 ** (RECIP_SHIFT - 1);
    // q >= OUT_MAX + 1  <=>  2N >= (2 * (OUT_MAX + 1) - 1) * d
    localparam int SAT_SCALE    = 2 * (OUT_MAX + 1) - 1;

    localparam int BP_CODE [NUM_POINTS] = '{
        1046, 1116, 1178, 1232, 1282, 1334, 1386, 1430,
        1476, 1522, 1620, 1658, 1746, 1830, 1876, 1956
    };

    localparam int BP_UA [NUM_POINTS] = '{
        100, 200, 300, 400, 500, 600, 700, 800,
        900, 1000, 1200, 1300, 1500, 1700, 1800, 2000
    };

    // floor(2^21 / (2d)) per segment
    localparam int SEG_RECIP [NUM_SEGS] = '{
        RECIP_NUM / 70, RECIP_NUM / 62, RECIP_NUM / 54, RECIP_NUM / 50,
        RECIP_NUM / 52, RECIP_NUM / 52, RECIP_NUM / 44, RECIP_NUM / 46,
        RECIP_NUM / 46, RECIP_NUM / 98, RECIP_NUM / 38, RECIP_NUM / 88,
        RECIP_NUM / 84, RECIP_NUM / 46, RECIP_NUM / 80
    };

    typedef struct packed {
        logic        [BP_W-1:0]   x1;
        logic signed [BASE_W-1:0] base;
        logic signed [DY_W-1:0]   dy;
        logic        [D_W-1:0]    d;
        logic        [LIM_W-1:0]  lim;
        logic        [RW-1:0]     recip;
    } seg_entry_t;

    function automatic seg_entry_t seg_entry(input int i);
        seg_entry_t e;
        int         d;
        int         dy;
        d       = BP_CODE[i + 1] - BP_CODE[i];
        dy      = BP_UA[i + 1] - BP_UA[i];
        e.x1    = BP_W'(BP_CODE[i]);
        e.base  = BASE_W'(BP_UA[i] * d);
        e.dy    = DY_W'(dy);
        e.d     = D_W'(d);
        e.lim   = LIM_W'(SAT_SCALE * d);
        e.recip = RW'(SEG_RECIP[i]);
        return e;
    endfunction

endpackage

[rtl/aplc_seg_rom.sv]
// Segment ROM: one entry per segment, registered read.
module aplc_seg_rom
(
    input  logic                           clk,
    input  logic                           rd_en,
    input  logic [aplc_pkg::SEG_W-1:0]     rd_addr,
    output aplc_pkg::seg_entry_t           rd_data
);

    aplc_pkg::seg_entry_t rom [aplc_pkg::NUM_SEGS];
    aplc_pkg::seg_entry_t rd_data_reg;

    for (genvar g = 0; g < aplc_pkg::NUM_SEGS; g++)
    begin : g_rom
        assign rom[g] = aplc_pkg::seg_entry(g);
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= rom[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/aplc_front.sv]
// Front stage: sign handling, code saturation and segment search.
module aplc_front
#(
    parameter int CODE_BITS = 12
)
(
    input  logic                            clk,
    input  logic                            en,
    input  logic                            signed_input,
    input  logic [aplc_pkg::SAMPLE_W-1:0]   sample,
    output logic [aplc_pkg::SEG_W-1:0]      seg_idx,
    output logic [CODE_BITS-1:0]            code,
    output logic                            neg
);

    localparam int MW = aplc_pkg::SAMPLE_W + 1;
    localparam int CW = (CODE_BITS > aplc_pkg::BP_W) ? CODE_BITS : aplc_pkg::BP_W;
    localparam logic [MW-1:0] MAX_CODE = MW'((2 ** CODE_BITS) - 1);

    logic [MW-1:0]        mag;
    logic                 neg_next;
    logic [CODE_BITS-1:0] code_next;
    logic [CODE_BITS-1:0] code_reg;
    logic                 neg_reg;

    always_comb
    begin
        neg_next = signed_input && sample[aplc_pkg::SAMPLE_W-1];
        if (neg_next)
        begin
            // most negative word gives 2^15 and saturates below
            mag = (MW'(1) << aplc_pkg::SAMPLE_W) - MW'(sample);
        end
        else
        begin
            mag = MW'(sample);
        end
        code_next = (mag > MAX_CODE) ? MAX_CODE[CODE_BITS-1:0] : mag[CODE_BITS-1:0];
    end

    // segment i covers [bp[i], bp[i+1]); outer segments extend outward
    always_comb
    begin
        seg_idx = '0;
        for (int j = 1; j < aplc_pkg::NUM_POINTS - 1; j++)
        begin
            if (CW'(code_next) >= CW'(aplc_pkg::BP_CODE[j]))
            begin
                seg_idx = aplc_pkg::SEG_W'(j);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            code_reg <= code_next;
            neg_reg  <= neg_next;
        end
    end

    assign code = code_reg;
    assign neg  = neg_reg;

endmodule

[rtl/aplc_interp.sv]
// Interpolation datapath: numerator, saturation, reciprocal divide, sign restore.
module aplc_interp
#(
    parameter int CODE_BITS = 12
)
(
    input  logic                                clk,
    input  logic                                en,
    input  logic [CODE_BITS-1:0]                code,
    input  logic                                neg,
    input  aplc_pkg::seg_entry_t                seg,
    output logic signed [aplc_pkg::OUT_W-1:0]   result
);

    localparam int CW   = (CODE_BITS > aplc_pkg::BP_W) ? CODE_BITS : aplc_pkg::BP_W;
    localparam int DW   = CW + 1;
    localparam int PW   = DW + aplc_pkg::DY_W;
    localparam int NW   = ((PW > aplc_pkg::BASE_W) ? PW : aplc_pkg::BASE_W) + 1;
    localparam int MPW  = aplc_pkg::TW + aplc_pkg::RW;
    localparam int QPW  = aplc_pkg::Q_W + aplc_pkg::D2_W;
    localparam int TW   = aplc_pkg::TW;
    localparam int Q_W  = aplc_pkg::Q_W;
    localparam int D2_W = aplc_pkg::D2_W;
    localparam int OUT_W = aplc_pkg::OUT_W;

    // stage 2: (x - x1) * dy
    logic signed [DW-1:0]      diff;
    logic signed [PW-1:0]      prod_next;
    logic signed [PW-1:0]      prod_reg;
    aplc_pkg::seg_entry_t      seg2_reg;
    logic                      neg2_reg;

    // stage 3: N = y1*d + (x - x1) * dy
    logic signed [NW-1:0]      num_next;
    logic signed [NW-1:0]      num_reg;
    aplc_pkg::seg_entry_t      seg3_reg;
    logic                      neg3_reg;

    // stage 4: t = 2N + d, sign and saturation flags
    logic signed [NW:0]        num2;
    logic [NW:0]               tsum;
    logic                      pos_next;
    logic                      sat_next;
    logic [TW-1:0]             t4_reg;
    logic                      pos4_reg;
    logic                      sat4_reg;
    logic                      neg4_reg;
    logic [D2_W-1:0]           d24_reg;
    logic [aplc_pkg::RW-1:0]   recip4_reg;

    // stage 5: t * recip
    logic [MPW-1:0]            m_next;
    logic [MPW-1:0]            m_reg;
    logic [TW-1:0]             t5_reg;
    logic                      pos5_reg;
    logic                      sat5_reg;
    logic                      neg5_reg;
    logic [D2_W-1:0]           d25_reg;

    // stage 6: q0 and q0 * 2d
    logic [Q_W-1:0]            q0_next;
    logic [QPW-1:0]            p_next;
    logic [Q_W-1:0]            q0_reg;
    logic [QPW-1:0]            p_reg;
    logic [TW-1:0]             t6_reg;
    logic                      pos6_reg;
    logic                      sat6_reg;
    logic                      neg6_reg;
    logic [D2_W-1:0]           d26_reg;

    // final correction
    logic [QPW-1:0]            rem;
    logic [Q_W:0]              q;
    logic [OUT_W-1:0]          mag;

    always_comb
    begin
        diff      = $signed(DW'(code)) - $signed(DW'(seg.x1));
        prod_next = PW'(diff) * PW'(seg.dy);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            seg2_reg <= seg;
            neg2_reg <= neg;
        end
    end

    assign num_next = NW'(seg2_reg.base) + NW'(prod_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg  <= num_next;
            seg3_reg <= seg2_reg;
            neg3_reg <= neg2_reg;
        end
    end

    always_comb
    begin
        num2     = {num_reg, 1'b0};
        pos_next = (num_reg > NW'(0));
        sat_next = (num2 >= $signed((NW + 1)'(seg3_reg.lim)));
        // only the low bits matter once saturation is ruled out
        tsum     = num2 + (NW + 1)'(seg3_reg.d);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t4_reg     <= tsum[TW-1:0];
            pos4_reg   <= pos_next;
            sat4_reg   <= sat_next;
            neg4_reg   <= neg3_reg;
            d24_reg    <= {seg3_reg.d, 1'b0};
            recip4_reg <= seg3_reg.recip;
        end
    end

    assign m_next = MPW'(t4_reg) * MPW'(recip4_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg    <= m_next;
            t5_reg   <= t4_reg;
            pos5_reg <= pos4_reg;
            sat5_reg <= sat4_reg;
            neg5_reg <= neg4_reg;
            d25_reg  <= d24_reg;
        end
    end

    // q0 is the exact quotient or one below it
    always_comb
    begin
        q0_next = m_reg[aplc_pkg::RECIP_SHIFT +: Q_W];
        p_next  = QPW'(q0_next) * QPW'(d25_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q0_reg   <= q0_next;
            p_reg    <= p_next;
            t6_reg   <= t5_reg;
            pos6_reg <= pos5_reg;
            sat6_reg <= sat5_reg;
            neg6_reg <= neg5_reg;
            d26_reg  <= d25_reg;
        end
    end

    always_comb
    begin
        rem = QPW'(t6_reg) - p_reg;
        q   = (Q_W + 1)'(q0_reg) + (Q_W + 1)'(rem >= QPW'(d26_reg));
        if (!pos6_reg)
        begin
            mag = '0;
        end
        else if (sat6_reg || (q > (Q_W + 1)'(aplc_pkg::OUT_MAX)))
        begin
            mag = OUT_W'(aplc_pkg::OUT_MAX);
        end
        else
        begin
            mag = q[OUT_W-1:0];
        end
        result = neg6_reg ? -$signed(mag) : $signed(mag);
    end

endmodule

[rtl/adc_piecewise_linear_calibration_core.sv]
// Top level of the ADC piecewise-linear calibration core.
// Converts one 16-bit converter word per beat into a current in microamps.
// In signed mode the word is taken as two's complement: its magnitude is
// calibrated and the sign is put back on the result. The magnitude saturates
// at 2^CODE_BITS - 1 and is mapped through a 16-point breakpoint ROM with
// linear interpolation (linear extrapolation outside the table), rounded to
// the nearest microamp with ties away from zero; negative currents clamp to
// zero and magnitudes clamp at 8191.
// Throughput: one sample per clock while the output is not held. The
// datapath is a fixed pipeline (segment search and ROM read, multiply, add,
// saturation check, reciprocal multiply, correction multiply, output
// register); the single-port segment ROM serves one lookup per cycle while
// the pipeline advances. When the output beat is held, the whole pipeline
// holds and s_axis_tready drops in the same cycle.
// signed_input is written through cfg_wr_en / cfg_wr_data and resets to 1;
// write it only while no sample is in flight.
module adc_piecewise_linear_calibration_core
#(
    parameter int CODE_BITS = 12
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    // input beat
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [aplc_pkg::IN_TDATA_W-1:0]        s_axis_tdata,  // [15:0] sample
    // output beat
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [aplc_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,  // [13:0] current_ua, [15:14] 0
    // signed_input register
    input  logic                                   cfg_wr_en,
    input  logic                                   cfg_wr_data
);

    // register stages between input and output register
    localparam int LAT = 6;

    logic                                   en;
    logic                                   accept;
    logic                                   signed_input_reg;
    logic                                   signed_input_next;
    logic [LAT-1:0]                         vld_reg;
    logic [LAT-1:0]                         vld_next;
    logic                                   m_valid_reg;
    logic                                   m_valid_next;
    logic signed [aplc_pkg::OUT_W-1:0]      result;
    logic signed [aplc_pkg::OUT_W-1:0]      m_data_reg;

    logic [aplc_pkg::SEG_W-1:0]             seg_idx;
    logic [CODE_BITS-1:0]                   code;
    logic                                   neg;
    aplc_pkg::seg_entry_t                   seg;

    // pipeline advances unless a finished beat is stuck at the output
    assign en            = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && en;
    assign s_axis_tready = en;

    assign signed_input_next = cfg_wr_en ? cfg_wr_data : signed_input_reg;

    always_comb
    begin
        vld_next     = vld_reg;
        m_valid_next = m_valid_reg;
        if (en)
        begin
            vld_next     = {vld_reg[LAT-2:0], accept};
            m_valid_next = vld_reg[LAT-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            signed_input_reg <= 1'b1;
            vld_reg          <= '0;
            m_valid_reg      <= 1'b0;
        end
        else
        begin
            signed_input_reg <= signed_input_next;
            vld_reg          <= vld_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_data_reg <= result;
        end
    end

    aplc_front #(
        .CODE_BITS    (CODE_BITS)
    ) u_front (
        .clk          (clk),
        .en           (en),
        .signed_input (signed_input_reg),
        .sample       (s_axis_tdata[aplc_pkg::SAMPLE_W-1:0]),
        .seg_idx      (seg_idx),
        .code         (code),
        .neg          (neg)
    );

    aplc_seg_rom u_seg_rom (
        .clk          (clk),
        .rd_en        (en),
        .rd_addr      (seg_idx),
        .rd_data      (seg)
    );

    aplc_interp #(
        .CODE_BITS    (CODE_BITS)
    ) u_interp (
        .clk          (clk),
        .en           (en),
        .code         (code),
        .neg          (neg),
        .seg          (seg),
        .result       (result)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(aplc_pkg::OUT_TDATA_W - aplc_pkg::OUT_W){1'b0}}, m_data_reg};

endmodule

[rtl/aplc_checker.sv]
// Port-level checker for the calibration core, bound to the top level.
`include "adc_piecewise_linear_calibration_core_defines.svh"

module aplc_checker
(
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 s_axis_tready,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [aplc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    // stalled output beat keeps its value
    `APLC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output beat changed while stalled")

    // input side opens exactly when the output register can move
    `APLC_ASSERT_ALWAYS(a_ready_link, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "s_axis_tready does not follow output stall")

    // padding bits above current_ua stay zero
    `APLC_ASSERT_ALWAYS(a_pad_zero, !m_axis_tvalid || (m_axis_tdata[15:14] == 2'b00), "tdata padding not zero")

    // magnitude clamp: the most negative 14-bit code never appears
    `APLC_ASSERT_ALWAYS(a_mag_clamp, !m_axis_tvalid || (m_axis_tdata[13:0] != 14'h2000), "current_ua outside clamp range")

endmodule

bind adc_piecewise_linear_calibration_core aplc_checker u_aplc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
